@@ rtl/wsd_pkg.sv @@
`default_nettype none

package wsd_pkg;

  // width of the max_payload register
  localparam int unsigned CfgW = 21;
  localparam logic [CfgW-1:0] MAX_PAYLOAD_RESET = 21'd1048576;

  // frame header codes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'ha;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam int unsigned PING_MAX_LEN  = 125;

  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_PING  = 3'd1,
    EV_CLOSE = 3'd2,
    EV_ERROR = 3'd3,
    EV_LONG  = 3'd4
  } ev_kind_e;

  // one result beat from the parser
  typedef struct packed {
    logic       valid;
    ev_kind_e   kind;
    logic [7:0] data;
    logic       has;
    logic       last;
  } wsd_event_t;

endpackage

`default_nettype wire

@@ rtl/wsd_parser.sv @@
`default_nettype none

module wsd_parser #(
  parameter int unsigned LENGTH_BITS = 21
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic [7:0]               rx_byte_i,
  input  wire logic                     connection_start_i,
  input  wire logic [wsd_pkg::CfgW-1:0] max_payload_i,
  output wsd_pkg::wsd_event_t           event_o
);
  import wsd_pkg::*;

  localparam int unsigned LW    = LENGTH_BITS;
  localparam int unsigned CMP_W = (LW + 1 > CfgW) ? LW + 1 : CfgW;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DEAD    = 3'd4
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    hdr0_q, hdr0_d;
  logic          mask_q, mask_d;
  logic [3:0]    ext_left_q, ext_left_d;
  logic [LW-1:0] flen_q, flen_d;
  logic          ovf_q, ovf_d;
  logic [LW-1:0] remain_q, remain_d;
  logic          frag_q, frag_d;
  logic [LW-1:0] msg_len_q, msg_len_d;
  logic          pend_q, pend_d;

  // parse one byte: phase step, then header checks, then end of frame
  always_comb begin
    logic [3:0]       opcode;
    logic             fin;
    logic             do_hdr;
    logic             do_end;
    logic             end_byte;
    logic [CMP_W-1:0] max_ext;
    logic [CMP_W-1:0] total;
    logic [6:0]       len7;

    phase_d    = phase_q;
    hdr0_d     = hdr0_q;
    mask_d     = mask_q;
    ext_left_d = ext_left_q;
    flen_d     = flen_q;
    ovf_d      = ovf_q;
    remain_d   = remain_q;
    frag_d     = frag_q;
    msg_len_d  = msg_len_q;
    pend_d     = pend_q;
    event_o    = '0;
    do_hdr     = 1'b0;
    do_end     = 1'b0;
    end_byte   = 1'b0;
    len7       = rx_byte_i[6:0];
    max_ext    = CMP_W'(max_payload_i);
    total      = '0;

    // new connection clears everything but the register
    if (connection_start_i) begin
      phase_d    = PH_HDR0;
      hdr0_d     = '0;
      mask_d     = 1'b0;
      ext_left_d = '0;
      flen_d     = '0;
      ovf_d      = 1'b0;
      remain_d   = '0;
      frag_d     = 1'b0;
      msg_len_d  = '0;
      pend_d     = 1'b0;
    end

    opcode = hdr0_d[3:0];
    fin    = hdr0_d[7];

    unique case (phase_d)
      PH_HDR0: begin
        hdr0_d  = rx_byte_i;
        phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        mask_d = rx_byte_i[7];
        flen_d = '0;
        ovf_d  = 1'b0;
        if (len7 == LEN_CODE_EXT16 || len7 == LEN_CODE_EXT64) begin
          ext_left_d = (len7 == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_d    = PH_EXT;
        end else begin
          flen_d = LW'(len7);
          do_hdr = 1'b1;
        end
      end
      PH_EXT: begin
        if (flen_d[LW-1 -: 8] != 8'd0) begin
          ovf_d = 1'b1;
        end
        flen_d     = LW'({flen_d, rx_byte_i});
        ext_left_d = ext_left_d - 4'd1;
        do_hdr     = (ext_left_d == 4'd0);
      end
      PH_PAYLOAD: begin
        remain_d = remain_d - LW'(1);
        if (remain_d == '0) begin
          do_end   = 1'b1;
          end_byte = 1'b1;
        end else if (!pend_d) begin
          if (opcode == OP_PING) begin
            event_o = '{valid: 1'b1, kind: EV_PING, data: rx_byte_i, has: 1'b1,
                        last: 1'b0};
          end else if (opcode == OP_TEXT || opcode == OP_CONT) begin
            event_o = '{valid: 1'b1, kind: EV_DATA, data: rx_byte_i, has: 1'b1,
                        last: 1'b0};
          end
        end
      end
      default: begin
        // dead parser ignores the byte
      end
    endcase

    // header complete: flag checks, length checks, fragment order
    if (do_hdr) begin
      total = CMP_W'(msg_len_d) + CMP_W'(flen_d);
      if (mask_d || hdr0_d[6:4] != 3'd0) begin
        phase_d = PH_DEAD;
        event_o = '{valid: 1'b1, kind: EV_ERROR, data: 8'd0, has: 1'b0, last: 1'b0};
      end else if (ovf_d || CMP_W'(flen_d) > max_ext) begin
        phase_d = PH_DEAD;
        event_o = '{valid: 1'b1, kind: EV_LONG, data: 8'd0, has: 1'b0, last: 1'b0};
      end else begin
        pend_d = 1'b0;
        if (opcode == OP_CLOSE || opcode == OP_PONG) begin
          do_end = (flen_d == '0);
        end else if (opcode == OP_PING) begin
          pend_d = (CMP_W'(flen_d) > CMP_W'(PING_MAX_LEN)) || !fin;
          do_end = (flen_d == '0);
        end else if (opcode != OP_TEXT && opcode != OP_CONT) begin
          pend_d = 1'b1;
          do_end = (flen_d == '0);
        end else if ((opcode == OP_CONT && !frag_d) ||
                     (opcode == OP_TEXT && frag_d)) begin
          pend_d = 1'b1;
          do_end = (flen_d == '0);
        end else if (total > max_ext) begin
          phase_d = PH_DEAD;
          event_o = '{valid: 1'b1, kind: EV_LONG, data: 8'd0, has: 1'b0, last: 1'b0};
        end else begin
          if (fin) begin
            frag_d    = 1'b0;
            msg_len_d = '0;
          end else begin
            frag_d    = 1'b1;
            msg_len_d = LW'(total);
          end
          do_end = (flen_d == '0);
        end
        if (!event_o.valid && flen_d != '0) begin
          remain_d = flen_d;
          phase_d  = PH_PAYLOAD;
        end
      end
    end

    // end of frame payload, or empty frame
    if (do_end) begin
      if (pend_d) begin
        phase_d = PH_DEAD;
        event_o = '{valid: 1'b1, kind: EV_ERROR, data: 8'd0, has: 1'b0, last: 1'b0};
      end else if (opcode == OP_CLOSE) begin
        phase_d = PH_DEAD;
        event_o = '{valid: 1'b1, kind: EV_CLOSE, data: 8'd0, has: 1'b0, last: 1'b0};
      end else begin
        phase_d = PH_HDR0;
        if (opcode == OP_PING) begin
          event_o = '{valid: 1'b1, kind: EV_PING, data: end_byte ? rx_byte_i : 8'd0,
                      has: end_byte, last: 1'b1};
        end else if (opcode == OP_PONG) begin
          event_o = '0;
        end else if (end_byte) begin
          event_o = '{valid: 1'b1, kind: EV_DATA, data: rx_byte_i, has: 1'b1,
                      last: fin};
        end else if (fin) begin
          event_o = '{valid: 1'b1, kind: EV_DATA, data: 8'd0, has: 1'b0, last: 1'b1};
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      hdr0_q     <= '0;
      mask_q     <= 1'b0;
      ext_left_q <= '0;
      flen_q     <= '0;
      ovf_q      <= 1'b0;
      remain_q   <= '0;
      frag_q     <= 1'b0;
      msg_len_q  <= '0;
      pend_q     <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      hdr0_q     <= hdr0_d;
      mask_q     <= mask_d;
      ext_left_q <= ext_left_d;
      flen_q     <= flen_d;
      ovf_q      <= ovf_d;
      remain_q   <= remain_d;
      frag_q     <= frag_d;
      msg_len_q  <= msg_len_d;
      pend_q     <= pend_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer_core.sv @@
// a received byte lands in the input register; the parse logic fills the result register
// once it is free, and the result register frees as it is taken
// throughput: one received byte per cycle while no result beat is held
// reset: parser waits for a first header byte, max_payload returns to 1048576,
// both register stages are emptied
`default_nettype none

module websocket_frame_deframer_core #(
  parameter int unsigned LENGTH_BITS = 21
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [wsd_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic [7:0]               rx_byte_i,
  input  wire logic                     connection_start_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic [2:0]               event_kind_o,
  output      logic [7:0]               data_byte_o,
  output      logic                     has_byte_o,
  output      logic                     last_o
);
  import wsd_pkg::*;

  logic [CfgW-1:0] max_payload_q;
  logic            in_vld_q;
  logic [7:0]      in_byte_q;
  logic            in_start_q;
  logic            out_vld_q;
  logic [2:0]      kind_q;
  logic [7:0]      data_q;
  logic            has_q;
  logic            last_q;
  logic            out_free;
  logic            step;
  wsd_event_t      ev;

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  // max_payload register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= rx_byte_i;
      in_start_q <= connection_start_i;
    end
  end

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .rx_byte_i         (in_byte_q),
    .connection_start_i(in_start_q),
    .max_payload_i     (max_payload_q),
    .event_o           (ev)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= step && ev.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && ev.valid) begin
      kind_q <= ev.kind;
      data_q <= ev.data;
      has_q  <= ev.has;
      last_q <= ev.last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_kind_o = kind_q;
  assign data_byte_o  = data_q;
  assign has_byte_o   = has_q;
  assign last_o       = last_q;

  // input side only stalls behind a held result beat
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // close, error and too-long beats carry no byte and no end mark
  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_CLOSE || event_kind_o == EV_ERROR ||
                    event_kind_o == EV_LONG) |-> (!has_byte_o && !last_o))
    else $error("status beat with data or last");

  // an empty data or ping beat is always an end marker
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o && (event_kind_o == EV_DATA || event_kind_o == EV_PING)
    |-> last_o)
    else $error("empty data beat without last");

  // no unknown event codes
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_kind_o <= EV_LONG))
    else $error("event kind out of range");

endmodule

`default_nettype wire

@@ dv/websocket_frame_deframer_core_tb.sv @@
`timescale 1ns / 1ps

module websocket_frame_deframer_core_tb;
  import wsd_pkg::*;

  localparam int unsigned LEN_W         = 21;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_BYTES   = 130;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PRINT_LIMIT   = 40;

  // length encodings on the wire
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  // receiver stall styles
  localparam int STALL_NONE  = 0;
  localparam int STALL_HALF  = 1;
  localparam int STALL_LIGHT = 2;
  localparam int STALL_HEAVY = 3;

  localparam logic [3:0] OP_RESERVED = 4'h3;

  typedef enum logic [2:0] {
    RX_HDR0, RX_HDR1, RX_EXT, RX_PAYLOAD, RX_DEAD
  } rx_phase_e;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] data;
    logic       has;
    logic       last;
  } ws_event_t;

  logic             clk_i;
  logic             rst_ni             = 1'b0;
  logic             cfg_we_i           = 1'b0;
  logic [CfgW-1:0]  cfg_data_i         = '0;
  logic             in_valid_i         = 1'b0;
  logic             in_ready_o;
  logic [7:0]       rx_byte_i          = 8'h00;
  logic             connection_start_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i        = 1'b0;
  logic [2:0]       event_kind_o;
  logic [7:0]       data_byte_o;
  logic             has_byte_o;
  logic             last_o;

  // parser state mirrored by the predictor
  rx_phase_e        rx_phase;
  logic [7:0]       hdr_first;
  logic             mask_seen;
  logic [3:0]       ext_left;
  logic [LEN_W-1:0] frame_len;
  logic             len_overflow;
  logic [LEN_W-1:0] bytes_left;
  logic             in_message;
  logic [LEN_W-1:0] message_len;
  logic             error_pending;
  logic [CfgW-1:0]  max_len;

  ws_event_t        expected_events[$];
  int unsigned      sent_bytes;
  int unsigned      mismatches;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  bit               hold_request;

  websocket_frame_deframer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .connection_start_i (connection_start_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_kind_o       (event_kind_o),
    .data_byte_o        (data_byte_o),
    .has_byte_o         (has_byte_o),
    .last_o             (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // deframing predictor

  function automatic void queue_event(ev_kind_e k, logic [7:0] d, logic h, logic l);
    ws_event_t e;
    e.kind = k;
    e.data = d;
    e.has  = h;
    e.last = l;
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic void clear_parser();
    rx_phase      = RX_HDR0;
    hdr_first     = '0;
    mask_seen     = 1'b0;
    ext_left      = '0;
    frame_len     = '0;
    len_overflow  = 1'b0;
    bytes_left    = '0;
    in_message    = 1'b0;
    message_len   = '0;
    error_pending = 1'b0;
  endfunction

  // end of a frame's payload, or straight after the header for an empty frame
  function automatic void close_frame(logic with_byte, logic [7:0] b);
    logic [3:0] op;
    logic       fin;
    op  = hdr_first[3:0];
    fin = hdr_first[7];
    if (error_pending) begin
      rx_phase = RX_DEAD;
      queue_event(EV_ERROR, 8'h00, 1'b0, 1'b0);
      return;
    end
    if (op == OP_CLOSE) begin
      rx_phase = RX_DEAD;
      queue_event(EV_CLOSE, 8'h00, 1'b0, 1'b0);
      return;
    end
    rx_phase = RX_HDR0;
    if (op == OP_PING)
      queue_event(EV_PING, with_byte ? b : 8'h00, with_byte, 1'b1);
    else if (op == OP_PONG)
      return;
    else if (with_byte)
      queue_event(EV_DATA, b, 1'b1, fin);
    else if (fin)
      queue_event(EV_DATA, 8'h00, 1'b0, 1'b1);
  endfunction

  // header complete: flag checks, length limits and fragment order
  function automatic void check_header();
    logic [3:0]     op;
    logic           fin;
    logic [LEN_W:0] total;
    op  = hdr_first[3:0];
    fin = hdr_first[7];
    if (mask_seen || hdr_first[6:4] != 3'b000) begin
      rx_phase = RX_DEAD;
      queue_event(EV_ERROR, 8'h00, 1'b0, 1'b0);
      return;
    end
    if (len_overflow || frame_len > max_len) begin
      rx_phase = RX_DEAD;
      queue_event(EV_LONG, 8'h00, 1'b0, 1'b0);
      return;
    end
    error_pending = 1'b0;
    if (op == OP_CLOSE || op == OP_PONG) begin
      // payload swallowed
    end else if (op == OP_PING) begin
      if (frame_len > LEN_W'(PING_MAX_LEN) || !fin) error_pending = 1'b1;
    end else if (op != OP_TEXT && op != OP_CONT) begin
      error_pending = 1'b1;
    end else if ((op == OP_CONT && !in_message) || (op == OP_TEXT && in_message)) begin
      error_pending = 1'b1;
    end else begin
      total = {1'b0, message_len} + {1'b0, frame_len};
      if (total > {1'b0, max_len}) begin
        rx_phase = RX_DEAD;
        queue_event(EV_LONG, 8'h00, 1'b0, 1'b0);
        return;
      end
      if (fin) begin
        in_message  = 1'b0;
        message_len = '0;
      end else begin
        in_message  = 1'b1;
        message_len = total[LEN_W-1:0];
      end
    end
    if (frame_len == '0) begin
      close_frame(1'b0, 8'h00);
      return;
    end
    bytes_left = frame_len;
    rx_phase   = RX_PAYLOAD;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic start);
    logic [3:0] op;
    if (start) clear_parser();
    case (rx_phase)
      RX_HDR0: begin
        hdr_first = b;
        rx_phase  = RX_HDR1;
      end
      RX_HDR1: begin
        mask_seen    = b[7];
        frame_len    = '0;
        len_overflow = 1'b0;
        if (b[6:0] == LEN_CODE_EXT16 || b[6:0] == LEN_CODE_EXT64) begin
          ext_left = (b[6:0] == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          rx_phase = RX_EXT;
        end else begin
          frame_len = LEN_W'(b[6:0]);
          check_header();
        end
      end
      RX_EXT: begin
        if (frame_len[LEN_W-1:LEN_W-8] != 8'h00) len_overflow = 1'b1;
        frame_len = {frame_len[LEN_W-9:0], b};
        ext_left  = ext_left - 4'd1;
        if (ext_left == 4'd0) check_header();
      end
      RX_PAYLOAD: begin
        bytes_left = bytes_left - LEN_W'(1);
        op = hdr_first[3:0];
        if (bytes_left == '0)
          close_frame(1'b1, b);
        else if (!error_pending) begin
          if (op == OP_PING)
            queue_event(EV_PING, b, 1'b1, 1'b0);
          else if (op == OP_TEXT || op == OP_CONT)
            queue_event(EV_DATA, b, 1'b1, 1'b0);
        end
      end
      default: begin
        // dead parser ignores everything
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic logic [7:0] hdr_flags(logic fin, logic [3:0] op);
    return {fin, 3'b000, op};
  endfunction

  function automatic logic need_fresh();
    return (rx_phase != RX_HDR0) || ($urandom_range(0, 39) == 0);
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 80) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 40);
    return $urandom_range(100, 140);
  endfunction

  function automatic int pick_form(int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (len > PING_MAX_LEN) return (r < 75) ? FORM_EXT16 : FORM_EXT64;
    if (r < 80) return FORM_SHORT;
    return (r < 92) ? FORM_EXT16 : FORM_EXT64;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // one byte beat, sent in bursts with random gaps in between
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i         <= 1'b1;
    rx_byte_i          <= b;
    connection_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    sent_bytes++;
    predict_byte(b, start);
  endtask

  task automatic send_frame(input logic [7:0] flags, input logic mask, input logic [63:0] len,
                            input int form, input int unsigned pay_cnt, input logic fresh);
    logic [7:0] wire_q[$];
    wire_q = {wire_q, flags};
    if (form == FORM_EXT16) begin
      wire_q = {wire_q, {mask, LEN_CODE_EXT16}};
      wire_q = {wire_q, len[15:8]};
      wire_q = {wire_q, len[7:0]};
    end else if (form == FORM_EXT64) begin
      wire_q = {wire_q, {mask, LEN_CODE_EXT64}};
      for (int i = 7; i >= 0; i--) wire_q = {wire_q, len[i*8 +: 8]};
    end else begin
      wire_q = {wire_q, {mask, len[6:0]}};
    end
    repeat (pay_cnt) wire_q = {wire_q, 8'($urandom_range(0, 255))};
    foreach (wire_q[i]) send_byte(wire_q[i], (i == 0) ? fresh : 1'b0);
  endtask

  // stop sending, let every expected beat drain and the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_payload(input logic [CfgW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    max_len     = value;
  endtask

  // one random sequence: mostly well-formed messages, the rest broken or noise
  task automatic send_random_sequence();
    int unsigned pick, sub, nfrag, len, cut;
    logic        fin, fresh;
    logic [3:0]  op;
    logic [63:0] big;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // text message in one or more fragments, control frames in between
      nfrag = $urandom_range(1, 4);
      fresh = need_fresh();
      for (int i = 0; i < nfrag; i++) begin
        if (i > 0 && rx_phase != RX_HDR0) break;
        if (i > 0 && $urandom_range(0, 3) == 0) begin
          len = $urandom_range(0, 10);
          op  = ($urandom_range(0, 1) != 0) ? OP_PING : OP_PONG;
          send_frame(hdr_flags(1'b1, op), 1'b0, 64'(len), FORM_SHORT, len, 1'b0);
          if (rx_phase != RX_HDR0) break;
        end
        fin = (i == nfrag - 1);
        len = pick_len();
        send_frame(hdr_flags(fin, (i == 0) ? OP_TEXT : OP_CONT), 1'b0, 64'(len),
                   pick_form(len), len, (i == 0) ? fresh : 1'b0);
      end
    end else if (pick < 65) begin
      // close, then bytes the dead parser must ignore
      len = $urandom_range(0, 4);
      send_frame(hdr_flags(1'b1, OP_CLOSE), 1'b0, 64'(len), pick_form(len), len,
                 need_fresh());
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 90) begin
      sub = $urandom_range(0, 99);
      if (sub < 25) begin
        // arbitrary flag byte, sometimes masked
        len = pick_len();
        send_frame(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 64'(len),
                   pick_form(len), len, need_fresh());
      end else if (sub < 40) begin
        // ping that is fragmented or too long
        if ($urandom_range(0, 1) != 0) begin
          len = $urandom_range(0, 10);
          send_frame(hdr_flags(1'b0, OP_PING), 1'b0, 64'(len), FORM_SHORT, len,
                     need_fresh());
        end else begin
          len = $urandom_range(126, 130);
          send_frame(hdr_flags(1'b1, OP_PING), 1'b0, 64'(len), FORM_EXT16, len,
                     need_fresh());
        end
      end else if (sub < 55) begin
        // frame cut short; the next sequence that sends a frame restarts the connection
        len = $urandom_range(5, 20);
        cut = $urandom_range(0, len - 1);
        send_frame(hdr_flags(1'($urandom_range(0, 1)), OP_TEXT), 1'b0, 64'(len),
                   pick_form(len), cut, need_fresh());
      end else if (sub < 70) begin
        // length that does not fit the length register
        big = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) big = 64'd1 << LEN_W;
        else if (big[63:LEN_W] == '0) big[63] = 1'b1;
        send_frame(hdr_flags(1'b1, OP_TEXT), 1'b0, big, FORM_EXT64, 0, need_fresh());
      end else if (sub < 85) begin
        // fragment order broken
        len = $urandom_range(0, 6);
        if ($urandom_range(0, 1) != 0) begin
          send_frame(hdr_flags(1'b1, OP_CONT), 1'b0, 64'(len), FORM_SHORT, len,
                     need_fresh());
        end else begin
          send_frame(hdr_flags(1'b0, OP_TEXT), 1'b0, 64'(len), FORM_SHORT, len,
                     need_fresh());
          if (rx_phase == RX_HDR0) begin
            len = $urandom_range(0, 6);
            send_frame(hdr_flags(1'b1, OP_TEXT), 1'b0, 64'(len), FORM_SHORT, len, 1'b0);
          end
        end
      end else begin
        // reserved opcode
        op = 4'($urandom_range(3, 12));
        if (op > 4'd7) op = op + 4'd3;
        len = $urandom_range(0, 8);
        send_frame(hdr_flags(1'($urandom_range(0, 1)), op), 1'b0, 64'(len), FORM_SHORT,
                   len, need_fresh());
      end
    end else begin
      // loose bytes with the odd connection restart
      cut = $urandom_range(1, 6);
      repeat (cut) send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_basic_frames();
    // final text frame with a zero byte
    send_byte(hdr_flags(1'b1, OP_TEXT), 1'b1);
    send_byte(8'd1, 1'b0);
    send_byte(8'h00, 1'b0);
    // first fragment with a 16-bit length, all-ones byte
    send_byte(hdr_flags(1'b0, OP_TEXT), 1'b0);
    send_byte({1'b0, LEN_CODE_EXT16}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'hff, 1'b0);
    // empty ping inside the message
    send_byte(hdr_flags(1'b1, OP_PING), 1'b0);
    send_byte(8'd0, 1'b0);
    // empty final continuation gives an end marker
    send_byte(hdr_flags(1'b1, OP_CONT), 1'b0);
    send_byte(8'd0, 1'b0);
    // pong is dropped
    send_byte(hdr_flags(1'b1, OP_PONG), 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'h5a, 1'b0);
    // empty close, then a byte the dead parser ignores
    send_byte(hdr_flags(1'b1, OP_CLOSE), 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_protocol_errors();
    // all flag bits and the mask bit set
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b0);
    // reserved opcode, empty
    send_byte(hdr_flags(1'b1, OP_RESERVED), 1'b1);
    send_byte(8'd0, 1'b0);
    // continuation outside a message, error after its payload
    send_byte(hdr_flags(1'b1, OP_CONT), 1'b1);
    send_byte(8'd1, 1'b0);
    send_byte(8'h33, 1'b0);
    // 64-bit length with the top bit set
    send_byte(hdr_flags(1'b1, OP_TEXT), 1'b1);
    send_byte({1'b0, LEN_CODE_EXT64}, 1'b0);
    send_byte(8'h80, 1'b0);
    repeat (7) send_byte(8'h00, 1'b0);
  endtask

  // receiver holds off for a long stretch while long frames keep coming
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_frame(hdr_flags(1'b1, OP_TEXT), 1'b0, 64'd120, FORM_SHORT, 120, 1'b1);
    send_frame(hdr_flags(1'b1, OP_TEXT), 1'b0, 64'd200, FORM_EXT16, 200, 1'b0);
  endtask

  task automatic test_random_traffic();
    logic [CfgW-1:0] limits [8];
    int unsigned     target;
    limits[0] = MAX_PAYLOAD_RESET;
    limits[1] = '0;
    limits[2] = CfgW'(1);
    limits[3] = '1;
    limits[4] = CfgW'(24);
    limits[5] = CfgW'(PING_MAX_LEN);
    limits[6] = CfgW'($urandom_range(2, 64));
    limits[7] = MAX_PAYLOAD_RESET;
    foreach (limits[i]) begin
      settle();
      write_max_payload(limits[i]);
      target = sent_bytes + PHASE_BYTES;
      while (sent_bytes < target) send_random_sequence();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver stalls: random runs of a few stall styles, long hold on request

  initial begin : result_sink
    int style;
    int unsigned run_len;
    forever begin
      style   = $urandom_range(STALL_NONE, STALL_HEAVY);
      run_len = $urandom_range(8, 60);
      repeat (run_len) begin
        @(posedge clk_i);
        if (hold_request) begin
          hold_request = 1'b0;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (style)
          STALL_NONE:  out_ready_i <= 1'b1;
          STALL_HALF:  out_ready_i <= ($urandom_range(0, 1) != 0);
          STALL_LIGHT: out_ready_i <= ($urandom_range(0, 3) != 0);
          default:     out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // compare every result beat with the oldest expectation
  initial begin : result_check
    ws_event_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind %0d data %02h has %0b last %0b",
                                    event_kind_o, data_byte_o, has_byte_o, last_o));
        end else begin
          want = expected_events.pop_front();
          if (event_kind_o !== want.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d", event_kind_o, want.kind));
          if (data_byte_o !== want.data)
            report_mismatch($sformatf("data_byte %02h, want %02h", data_byte_o, want.data));
          if (has_byte_o !== want.has)
            report_mismatch($sformatf("has_byte %0b, want %0b", has_byte_o, want.has));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** websocket_frame_deframer_core: FAILED **");
    $finish;
  end

  initial begin : run
    int unsigned waited;
    sent_bytes   = 0;
    mismatches   = 0;
    burst_left   = 0;
    hold_request = 1'b0;
    max_len      = MAX_PAYLOAD_RESET;
    clear_parser();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_frames();
    test_protocol_errors();
    test_backpressure();
    test_random_traffic();

    // drain what is still in flight
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", expected_events.size()));
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);
    if (mismatches == 0)
      $display("** websocket_frame_deframer_core: PASSED **");
    else
      $display("** websocket_frame_deframer_core: FAILED **");
    $finish;
  end

endmodule
